// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the GF(2^m) minimal polynomial unit.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");

// next-cycle implication, disabled during reset
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`endif

// ===== rtl/gfm_pkg.sv =====
// ----------------------------------------------------------------------------
// gfm_pkg
// Field widths, register indexes, reset values and control and status structs of the minimal polynomial unit.
// ----------------------------------------------------------------------------
package gfm_pkg;

   localparam int ALPHA_W     = 12;
   localparam int COEF_W      = 12;
   localparam int POWER_W     = 4;
   localparam int DEGREE_W    = 4;
   localparam int POLY_W      = 13;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 13;
   localparam int MIN_DEGREE  = 3;

   localparam logic [CSR_INDEX_W-1:0] CSR_FIELD_DEGREE = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_FIELD_POLY   = 2'd1;

   localparam logic [DEGREE_W-1:0] DEGREE_RESET = 4'd8;
   localparam logic [POLY_W-1:0]   POLY_RESET   = 13'd285;

   typedef struct packed {
      logic busy;
      logic done;
   } gfm_mul_status_type;

   typedef struct packed {
      logic init;
      logic step;
      logic use_prod;
   } gfm_line_ctl_type;

endpackage

// ===== rtl/gfm_serial_mul.sv =====
// ----------------------------------------------------------------------------
// gfm_serial_mul
// Bit-serial GF(2^m) multiplier: one bit of b per cycle, m bits of b per product.
// ----------------------------------------------------------------------------
module gfm_serial_mul #(
   parameter int ELEM_W = 12
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic [ELEM_W-1:0]                   a,
   input  logic [ELEM_W-1:0]                   b,
   input  logic [ELEM_W-1:0]                   mask,
   input  logic [ELEM_W-1:0]                   red,
   input  logic [$clog2(ELEM_W+1)-1:0]         degree,
   output logic [ELEM_W-1:0]                   product,
   output gfm_pkg::gfm_mul_status_type         status
);
   import gfm_pkg::*;

   localparam int CNT_W = $clog2(ELEM_W + 1);

   logic [ELEM_W-1:0] a_ff, a_in;
   logic [ELEM_W-1:0] b_ff, b_in;
   logic [ELEM_W-1:0] acc_ff, acc_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [ELEM_W:0]   shifted;

   always_comb begin
      shifted = {a_ff, 1'b0};
      a_in    = a_ff;
      b_in    = b_ff;
      acc_in  = acc_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         a_in    = a;
         b_in    = b;
         acc_in  = '0;
         cnt_in  = degree;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         acc_in = acc_ff ^ (b_ff[0] ? a_ff : '0);
         b_in   = b_ff >> 1;
         // times x, folding the x^m term back through the reduction bits
         a_in   = (shifted[ELEM_W-1:0] & mask) ^ (shifted[degree] ? red : '0);
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      a_ff   <= a_in;
      b_ff   <= b_in;
      acc_ff <= acc_in;
      cnt_ff <= cnt_in;
   end

   assign product     = acc_ff;
   assign status.busy = busy_ff;
   assign status.done = done_ff;

endmodule

// ===== rtl/gfm_coef_line.sv =====
// ----------------------------------------------------------------------------
// gfm_coef_line
// Circular coefficient shift line; each step folds in (x + r) one term at a time.
// ----------------------------------------------------------------------------
module gfm_coef_line #(
   parameter int ELEM_W = 12
) (
   input  logic                       clock,
   input  gfm_pkg::gfm_line_ctl_type  ctl,
   input  logic [ELEM_W-1:0]          prod,
   output logic [ELEM_W-1:0]          head
);
   import gfm_pkg::*;

   localparam int DEPTH = ELEM_W + 1;

   logic [ELEM_W-1:0] line_ff [DEPTH];
   logic [ELEM_W-1:0] line_in [DEPTH];
   logic [ELEM_W-1:0] prev_ff, prev_in;

   always_comb begin
      for (int j = 0; j < DEPTH; j++) begin
         line_in[j] = line_ff[j];
      end
      prev_in = prev_ff;
      if (ctl.init) begin
         for (int j = 0; j < DEPTH; j++) begin
            line_in[j] = '0;
         end
         line_in[0] = ELEM_W'(1);
         prev_in    = '0;
      end else if (ctl.step) begin
         // new[i] = old[i-1] ^ old[i]*r, pushed at the tail as old[i] leaves the head
         for (int j = 0; j < DEPTH - 1; j++) begin
            line_in[j] = line_ff[j + 1];
         end
         line_in[DEPTH-1] = prev_ff ^ (ctl.use_prod ? prod : '0);
         prev_in          = line_ff[0];
      end
   end

   always_ff @(posedge clock) begin
      for (int j = 0; j < DEPTH; j++) begin
         line_ff[j] <= line_in[j];
      end
      prev_ff <= prev_in;
   end

   assign head = line_ff[0];

endmodule

// ===== rtl/gf2m_minimal_polynomial_unit.sv =====
// ----------------------------------------------------------------------------
// gf2m_minimal_polynomial_unit
// Minimal polynomial of one GF(2^m) element over a bit-serial multiplier.
// ----------------------------------------------------------------------------
//  channel  | ports                                           | transfer
//  ---------+-------------------------------------------------+-----------------------
//  request  | start, busy, req_alpha                          | start & !busy
//  response | rsp_valid, rsp_coefficient, rsp_power_index,    | every rsp_valid cycle
//           | rsp_last                                        |
//  config   | csr_write_enable, csr_index, csr_write_data     | csr_write_enable
//
//  Every expansion product goes through one bit-serial multiplier, as does every squaring.
//  With n conjugates an item costs n(n+1)/2 such products and n squarings; for each
//  conjugate the terms above its degree are shifted without a product, and a repeat
//  search of the recorded conjugates precedes it; after the accept come n+1 results.
//  Reset is synchronous; config returns to m = 8, polynomial 0x11D.
//  Results come one per cycle and cannot be held off.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module gf2m_minimal_polynomial_unit #(
   parameter int MAX_DEGREE = 12
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  logic [gfm_pkg::ALPHA_W-1:0]        req_alpha,
   output logic                               rsp_valid,
   output logic [gfm_pkg::COEF_W-1:0]         rsp_coefficient,
   output logic [gfm_pkg::POWER_W-1:0]        rsp_power_index,
   output logic                               rsp_last,
   input  logic                               csr_write_enable,
   input  logic [gfm_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [gfm_pkg::CSR_DATA_W-1:0]     csr_write_data
);
   import gfm_pkg::*;

   localparam int CNT_W = $clog2(MAX_DEGREE + 1);
   localparam int IDX_W = $clog2(MAX_DEGREE);

   localparam logic [2:0] ST_IDLE     = 3'd0;
   localparam logic [2:0] ST_CHECK    = 3'd1;
   localparam logic [2:0] ST_EXPAND   = 3'd2;
   localparam logic [2:0] ST_EXP_WAIT = 3'd3;
   localparam logic [2:0] ST_SQ_WAIT  = 3'd4;
   localparam logic [2:0] ST_EMIT     = 3'd5;

   logic [DEGREE_W-1:0]   degree_ff;
   logic [POLY_W-1:0]     poly_ff;
   logic [2:0]            state_ff, state_in;
   logic [MAX_DEGREE-1:0] cur_ff, cur_in;
   logic [CNT_W-1:0]      n_ff, n_in;
   logic [CNT_W-1:0]      scan_ff, scan_in;
   logic [CNT_W-1:0]      pos_ff, pos_in;
   logic [CNT_W-1:0]      out_idx_ff, out_idx_in;
   logic [MAX_DEGREE-1:0] roots_ff [MAX_DEGREE];
   logic                  root_we;

   logic [4:0]                    degree_ext;
   logic [CNT_W-1:0]              eff_m;
   logic [MAX_DEGREE-1:0]         mask;
   logic [MAX_DEGREE+POLY_W-1:0]  poly_wide;
   logic [MAX_DEGREE+ALPHA_W-1:0] alpha_wide;
   logic [MAX_DEGREE-1:0]         red;
   logic [MAX_DEGREE-1:0]         alpha_m;
   logic [COEF_W+MAX_DEGREE-1:0]  coef_wide;
   logic [POWER_W+CNT_W-1:0]      power_wide;

   logic                  mul_start;
   logic [MAX_DEGREE-1:0] mul_a;
   logic [MAX_DEGREE-1:0] mul_product;
   gfm_mul_status_type    mul_status;
   gfm_line_ctl_type      line_ctl;
   logic [MAX_DEGREE-1:0] head;
   logic                  accept;

   // effective degree and masks
   always_comb begin
      degree_ext = {1'b0, degree_ff};
      if (degree_ext < 5'(MIN_DEGREE)) begin
         eff_m = CNT_W'(MIN_DEGREE);
      end else if (degree_ext > 5'(MAX_DEGREE)) begin
         eff_m = CNT_W'(MAX_DEGREE);
      end else begin
         eff_m = CNT_W'(degree_ext);
      end
      for (int b = 0; b < MAX_DEGREE; b++) begin
         mask[b] = (CNT_W'(b) < eff_m);
      end
      poly_wide  = {{MAX_DEGREE{1'b0}}, poly_ff};
      alpha_wide = {{MAX_DEGREE{1'b0}}, req_alpha};
      red        = poly_wide[MAX_DEGREE-1:0] & mask;
      alpha_m    = alpha_wide[MAX_DEGREE-1:0] & mask;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         degree_ff <= DEGREE_RESET;
         poly_ff   <= POLY_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_FIELD_DEGREE: degree_ff <= csr_write_data[DEGREE_W-1:0];
            CSR_FIELD_POLY:   poly_ff   <= csr_write_data[POLY_W-1:0];
            default: ;
         endcase
      end
   end

   assign busy   = (state_ff != ST_IDLE);
   assign accept = start && !busy;

   always_comb begin
      state_in          = state_ff;
      cur_in            = cur_ff;
      n_in              = n_ff;
      scan_in           = scan_ff;
      pos_in            = pos_ff;
      out_idx_in        = out_idx_ff;
      root_we           = 1'b0;
      mul_start         = 1'b0;
      mul_a             = cur_ff;
      line_ctl.init     = 1'b0;
      line_ctl.step     = 1'b0;
      line_ctl.use_prod = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cur_in        = alpha_m;
               n_in          = '0;
               scan_in       = '0;
               line_ctl.init = 1'b1;
               state_in      = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (n_ff == eff_m) begin
               out_idx_in = '0;
               state_in   = ST_EMIT;
            end else if (scan_ff == n_ff) begin
               // new conjugate: record it and multiply the polynomial by (x + cur)
               root_we  = 1'b1;
               pos_in   = '0;
               state_in = ST_EXPAND;
            end else if (roots_ff[scan_ff[IDX_W-1:0]] == cur_ff) begin
               out_idx_in = '0;
               state_in   = ST_EMIT;
            end else begin
               scan_in = scan_ff + 1'b1;
            end
         end
         ST_EXPAND: begin
            if (pos_ff <= n_ff) begin
               mul_start = 1'b1;
               mul_a     = head;
               state_in  = ST_EXP_WAIT;
            end else begin
               // terms above the current degree are zero: shift without a product
               line_ctl.step = 1'b1;
               if (pos_ff == CNT_W'(MAX_DEGREE)) begin
                  mul_start = 1'b1;
                  state_in  = ST_SQ_WAIT;
               end else begin
                  pos_in = pos_ff + 1'b1;
               end
            end
         end
         ST_EXP_WAIT: begin
            if (mul_status.done) begin
               line_ctl.step     = 1'b1;
               line_ctl.use_prod = 1'b1;
               pos_in            = pos_ff + 1'b1;
               state_in          = ST_EXPAND;
            end
         end
         ST_SQ_WAIT: begin
            if (mul_status.done) begin
               cur_in   = mul_product;
               n_in     = n_ff + 1'b1;
               scan_in  = '0;
               state_in = ST_CHECK;
            end
         end
         ST_EMIT: begin
            line_ctl.step = 1'b1;
            out_idx_in    = out_idx_ff + 1'b1;
            if (out_idx_ff == n_ff) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff     <= cur_in;
      n_ff       <= n_in;
      scan_ff    <= scan_in;
      pos_ff     <= pos_in;
      out_idx_ff <= out_idx_in;
      if (root_we) begin
         roots_ff[n_ff[IDX_W-1:0]] <= cur_ff;
      end
   end

   gfm_serial_mul #(
      .ELEM_W (MAX_DEGREE)
   ) u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .a       (mul_a),
      .b       (cur_ff),
      .mask    (mask),
      .red     (red),
      .degree  (eff_m),
      .product (mul_product),
      .status  (mul_status)
   );

   gfm_coef_line #(
      .ELEM_W (MAX_DEGREE)
   ) u_line (
      .clock (clock),
      .ctl   (line_ctl),
      .prod  (mul_product),
      .head  (head)
   );

   assign coef_wide       = {{COEF_W{1'b0}}, head};
   assign power_wide      = {{POWER_W{1'b0}}, out_idx_ff};
   assign rsp_valid       = (state_ff == ST_EMIT);
   assign rsp_coefficient = coef_wide[COEF_W-1:0];
   assign rsp_power_index = power_wide[POWER_W-1:0];
   assign rsp_last        = rsp_valid && (out_idx_ff == n_ff);

   `ASSERT_IMPLY(a_rsp_only_busy, clock, reset, rsp_valid, busy)
   `ASSERT_IMPLY(a_mul_start_idle, clock, reset, mul_start, !mul_status.busy)
   `ASSERT_NEXT(a_last_ends_run, clock, reset, rsp_valid && rsp_last, !busy)
   `ASSERT_IMPLY(a_conj_bound, clock, reset, state_ff == ST_CHECK, n_ff <= eff_m)

endmodule
